/* rtl/biq_pkg.sv */
// biq_pkg: widths, register indexes, datapath command types and saturation helpers
// for the biquad filter; no dependencies, imported by every module of the block

package biq_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int COEF_WIDTH     = 18;
   localparam int STATE_WIDTH    = SAMPLE_WIDTH + COEF_FRAC_BITS + 6;

   // the output value w is multiplied in two halves
   localparam int W_LO_WIDTH  = STATE_WIDTH / 2;
   localparam int W_HI_WIDTH  = STATE_WIDTH - W_LO_WIDTH;
   localparam int MUL_B_PRE   = (W_HI_WIDTH > W_LO_WIDTH + 1) ? W_HI_WIDTH : W_LO_WIDTH + 1;
   localparam int MUL_B_WIDTH = (SAMPLE_WIDTH > MUL_B_PRE) ? SAMPLE_WIDTH : MUL_B_PRE;
   localparam int PROD_WIDTH  = COEF_WIDTH + MUL_B_WIDTH;
   localparam int ACC_WIDTH   = COEF_WIDTH + STATE_WIDTH + 2;
   localparam int RND_WIDTH   = ACC_WIDTH - COEF_FRAC_BITS;
   localparam int SUM_WIDTH   = RND_WIDTH + 2;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_B0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_B1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_B2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_A1 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_A2 = 3'd4;

   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(2 ** COEF_FRAC_BITS);
   localparam logic signed [ACC_WIDTH-1:0]  ACC_HALF = ACC_WIDTH'(2 ** (COEF_FRAC_BITS - 1));
   localparam logic signed [SUM_WIDTH-1:0]  SUM_HALF = SUM_WIDTH'(2 ** (COEF_FRAC_BITS - 1));

   localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      SEL_B0,
      SEL_B1,
      SEL_B2,
      SEL_A1,
      SEL_A2
   } coef_sel_type;

   typedef enum logic [1:0] {
      OPND_X,
      OPND_W_LO,
      OPND_W_HI
   } opnd_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD_HI
   } acc_op_type;

   typedef struct packed {
      logic         load_x;
      logic         mul_en;
      coef_sel_type mul_coef;
      opnd_sel_type mul_opnd;
      logic         load_w;
      acc_op_type   acc_op;
      logic         load_r1;
      logic         load_r2;
      logic         upd_d1;
      logic         upd_d2;
      logic         load_out;
   } dp_cmd_type;

   function automatic logic signed [STATE_WIDTH-1:0] sat_state(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic signed [SUM_WIDTH-1:0] hi;
      logic signed [SUM_WIDTH-1:0] lo;
      hi = SUM_WIDTH'(STATE_MAX);
      lo = SUM_WIDTH'(STATE_MIN);
      if (v > hi) begin
         return STATE_MAX;
      end else if (v < lo) begin
         return STATE_MIN;
      end
      return v[STATE_WIDTH-1:0];
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic signed [SUM_WIDTH-1:0] hi;
      logic signed [SUM_WIDTH-1:0] lo;
      hi = SUM_WIDTH'(SAMPLE_MAX);
      lo = SUM_WIDTH'(SAMPLE_MIN);
      if (v > hi) begin
         return SAMPLE_MAX;
      end else if (v < lo) begin
         return SAMPLE_MIN;
      end
      return v[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

/* rtl/biq_datapath.sv */
// biq_datapath: coefficient registers, shared multiplier, accumulator and filter state
// depends on biq_pkg; steered cycle by cycle by biq_ctrl through dp_cmd_type

module biq_datapath
   import biq_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  dp_cmd_type                        cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
   output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
   input  logic                              csr_write_en,
   input  logic        [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic signed [COEF_WIDTH-1:0]      csr_data
);

   logic signed [COEF_WIDTH-1:0]   b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [STATE_WIDTH-1:0]  w_ff, w_in;
   logic signed [PROD_WIDTH-1:0]   prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic signed [RND_WIDTH-1:0]    r1_ff, r2_ff, rnd_in;
   logic signed [STATE_WIDTH-1:0]  d1_ff, d1_in, d2_ff, d2_in;
   logic signed [SAMPLE_WIDTH-1:0] out_ff, out_in;
   logic signed [COEF_WIDTH-1:0]   mul_a;
   logic signed [MUL_B_WIDTH-1:0]  mul_b;
   logic signed [SUM_WIDTH-1:0]    y_rnd;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= COEF_ONE;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_B0:  b0_ff <= csr_data;
            CSR_B1:  b1_ff <= csr_data;
            CSR_B2:  b2_ff <= csr_data;
            CSR_A1:  a1_ff <= csr_data;
            CSR_A2:  a2_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      case (cmd.mul_coef)
         SEL_B0:  mul_a = b0_ff;
         SEL_B1:  mul_a = b1_ff;
         SEL_B2:  mul_a = b2_ff;
         SEL_A1:  mul_a = a1_ff;
         SEL_A2:  mul_a = a2_ff;
         default: mul_a = b0_ff;
      endcase
      case (cmd.mul_opnd)
         OPND_X:    mul_b = MUL_B_WIDTH'(x_ff);
         OPND_W_LO: mul_b = MUL_B_WIDTH'($signed({1'b0, w_ff[W_LO_WIDTH-1:0]}));
         OPND_W_HI: mul_b = MUL_B_WIDTH'($signed(w_ff[STATE_WIDTH-1:W_LO_WIDTH]));
         default:   mul_b = MUL_B_WIDTH'(x_ff);
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD:   acc_in = ACC_WIDTH'(prod_ff) + ACC_HALF;
         ACC_ADD_HI: acc_in = acc_ff + (ACC_WIDTH'(prod_ff) <<< W_LO_WIDTH);
         default:    acc_in = acc_ff;
      endcase
   end

   assign rnd_in = RND_WIDTH'(acc_ff >>> COEF_FRAC_BITS);
   assign w_in   = sat_state(SUM_WIDTH'(prod_ff) + SUM_WIDTH'(d1_ff));
   assign d1_in  = sat_state(SUM_WIDTH'(prod_ff) + SUM_WIDTH'(d2_ff) - SUM_WIDTH'(r1_ff));
   assign d2_in  = sat_state(SUM_WIDTH'(prod_ff) - SUM_WIDTH'(r2_ff));
   assign y_rnd  = (SUM_WIDTH'(w_ff) + SUM_HALF) >>> COEF_FRAC_BITS;
   assign out_in = sat_sample(y_rnd);

   always_ff @(posedge clock) begin
      if (cmd.load_x)   x_ff    <= sample_in;
      if (cmd.mul_en)   prod_ff <= prod_in;
      if (cmd.load_w)   w_ff    <= w_in;
      acc_ff <= acc_in;
      if (cmd.load_r1)  r1_ff   <= rnd_in;
      if (cmd.load_r2)  r2_ff   <= rnd_in;
      if (cmd.load_out) out_ff  <= out_in;
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         if (cmd.upd_d1) d1_ff <= d1_in;
         if (cmd.upd_d2) d2_ff <= d2_in;
      end
   end

   assign sample_out = out_ff;

endmodule

/* rtl/biq_ctrl.sv */
// biq_ctrl: sequencer for one sample through the shared multiplier, plus handshakes
// depends on biq_pkg; drives biq_datapath through dp_cmd_type

module biq_ctrl
   import biq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_MUL_B0 = 10'b0000000010,
      ST_CALC_W = 10'b0000000100,
      ST_A1_LO  = 10'b0000001000,
      ST_A1_HI  = 10'b0000010000,
      ST_A2_LO  = 10'b0000100000,
      ST_A2_HI  = 10'b0001000000,
      ST_MUL_B1 = 10'b0010000000,
      ST_MUL_B2 = 10'b0100000000,
      ST_FINISH = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_load;

   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && can_load));
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.mul_coef = SEL_B0;
      cmd.mul_opnd = OPND_X;
      cmd.acc_op   = ACC_HOLD;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_x = 1'b1;
               state_in   = ST_MUL_B0;
            end
         end
         ST_MUL_B0: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_CALC_W;
         end
         ST_CALC_W: begin
            cmd.load_w = 1'b1;
            state_in   = ST_A1_LO;
         end
         ST_A1_LO: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = SEL_A1;
            cmd.mul_opnd = OPND_W_LO;
            state_in     = ST_A1_HI;
         end
         ST_A1_HI: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = SEL_A1;
            cmd.mul_opnd = OPND_W_HI;
            cmd.acc_op   = ACC_LOAD;
            state_in     = ST_A2_LO;
         end
         ST_A2_LO: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = SEL_A2;
            cmd.mul_opnd = OPND_W_LO;
            cmd.acc_op   = ACC_ADD_HI;
            state_in     = ST_A2_HI;
         end
         ST_A2_HI: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = SEL_A2;
            cmd.mul_opnd = OPND_W_HI;
            cmd.acc_op   = ACC_LOAD;
            cmd.load_r1  = 1'b1;
            state_in     = ST_MUL_B1;
         end
         ST_MUL_B1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = SEL_B1;
            cmd.acc_op   = ACC_ADD_HI;
            state_in     = ST_MUL_B2;
         end
         ST_MUL_B2: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_coef = SEL_B2;
            cmd.load_r2  = 1'b1;
            cmd.upd_d1   = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (can_load) begin
               cmd.upd_d2   = 1'b1;
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               if (req_valid) begin
                  cmd.load_x = 1'b1;
                  state_in   = ST_MUL_B0;
               end else begin
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/biquad_iir_filter.sv */
// biquad_iir_filter: top level of the second-order iir section (transposed direct form ii)
// depends on biq_pkg, biq_ctrl and biq_datapath

// One signed 16-bit sample in, one rounded and saturated 16-bit sample out, for each
// transfer. Coefficients b0, b1, b2, a1, a2 are signed Q3.14 in csr registers 0..4
// (b0 resets to 1.0, the rest to 0, so the filter passes samples through after reset);
// the a terms are subtracted. Internal state is 36 bits with 14 fraction bits and
// saturates instead of wrapping. All seven products of a sample go through one 18x19
// multiplier, one product per cycle; w times a coefficient is built from two halves of w.
// From its transfer a sample steps through MUL_B0, CALC_W, A1_LO, A1_HI, A2_LO, A2_HI,
// MUL_B1, MUL_B2 and FINISH to the result register; the next sample transfers at the
// earliest in the cycle the result is loaded. The result sits in an output register,
// so a stalled result does not block the next transfer; only the following result waits
// for it. Write the coefficients only while the block is idle.

module biquad_iir_filter
   import biq_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   // sample input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_sample_in,
   // filtered sample channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]    rsp_sample_out,
   // coefficient write port
   input  logic                              csr_write_en,
   input  logic        [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic signed [COEF_WIDTH-1:0]      csr_data
);

   dp_cmd_type cmd;

   // sequencer: one state per multiplier cycle
   biq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // coefficients, multiplier, accumulator, state and result register
   biq_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sample_in    (req_sample_in),
      .sample_out   (rsp_sample_out),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // a transfer in starts a sample, so the block is busy in the next cycle
   a_busy_after_transfer : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a sample was starting");

   // the result register is only overwritten once the previous result has gone
   a_no_result_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten before its transfer");

   // the first state update (MUL_B2) follows the output value (CALC_W) after states A1_LO to MUL_B1
   a_fixed_schedule : assert property (@(posedge clock) disable iff (reset)
      cmd.load_w |-> ##6 cmd.upd_d1)
      else $error("state update out of schedule");

   // the output value and the two feedback states are never updated in the same cycle
   a_state_once : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_w, cmd.upd_d1, cmd.upd_d2}))
      else $error("overlapping state updates");

endmodule

/* bench/biquad_response_checker.sv */
// biquad_response_checker: watches the sample, result and coefficient ports of the biquad
// filter, predicts each filtered sample in fixed point and compares it; uses biq_pkg

module biquad_response_checker
   import biq_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_sample_in,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]    rsp_sample_out,
   input  logic                              csr_write_en,
   input  logic        [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic signed [COEF_WIDTH-1:0]      csr_data,
   output int                                fail_count,
   output int                                pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   logic signed [COEF_WIDTH-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
   logic signed [STATE_WIDTH-1:0]  delay_one, delay_two;
   logic signed [SAMPLE_WIDTH-1:0] expected_outputs[$];
   logic signed [SAMPLE_WIDTH-1:0] next_expected;
   int                             errors = 0;

   function automatic longint clamp(input longint v, input int width);
      longint hi;
      hi = (longint'(1) <<< (width - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // one filter step: returns the output sample and advances both delay registers
   function automatic logic signed [SAMPLE_WIDTH-1:0] filter_step(
      input logic signed [SAMPLE_WIDTH-1:0] x
   );
      longint xs, w, half, n1, n2;
      xs   = longint'(x);
      half = longint'(1) <<< (COEF_FRAC_BITS - 1);
      w    = clamp(longint'(coef_b0) * xs + longint'(delay_one), STATE_WIDTH);
      // a terms are rounded half up and subtracted
      n1   = clamp(longint'(coef_b1) * xs + longint'(delay_two)
                   - ((longint'(coef_a1) * w + half) >>> COEF_FRAC_BITS), STATE_WIDTH);
      n2   = clamp(longint'(coef_b2) * xs
                   - ((longint'(coef_a2) * w + half) >>> COEF_FRAC_BITS), STATE_WIDTH);
      delay_one = STATE_WIDTH'(n1);
      delay_two = STATE_WIDTH'(n2);
      return SAMPLE_WIDTH'(clamp((w + half) >>> COEF_FRAC_BITS, SAMPLE_WIDTH));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         coef_b0   = COEF_ONE;
         coef_b1   = '0;
         coef_b2   = '0;
         coef_a1   = '0;
         coef_a2   = '0;
         delay_one = '0;
         delay_two = '0;
         expected_outputs.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               $error("sample_out: expected none, actual %0d", rsp_sample_out);
               errors++;
            end else begin
               next_expected = expected_outputs.pop_front();
               if (rsp_sample_out !== next_expected) begin
                  $error("sample_out: expected %0d, actual %0d", next_expected,
                         rsp_sample_out);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_outputs.push_back(filter_step(req_sample_in));
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_B0: coef_b0 = csr_data;
               CSR_B1: coef_b1 = csr_data;
               CSR_B2: coef_b2 = csr_data;
               CSR_A1: coef_a1 = csr_data;
               CSR_A2: coef_a2 = csr_data;
               default: ;
            endcase
         end
      end
      fail_count    <= errors;
      pending_count <= expected_outputs.size();
   end

endmodule

/* bench/tb_biquad_iir_filter.sv */
// tb_biquad_iir_filter: stimulus and verdict for the biquad filter; drives samples and
// coefficient writes, the checker instance predicts and compares
// depends on biq_pkg, biquad_iir_filter and biquad_response_checker

module tb_biquad_iir_filter
   import biq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD     = 4;
   localparam int IDLE_PERCENT    = 19;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 20;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int CYCLE_LIMIT     = 200000;

   localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic signed [SAMPLE_WIDTH-1:0]    req_sample_in;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic signed [SAMPLE_WIDTH-1:0]    rsp_sample_out;
   logic                              csr_write_en;
   logic        [CSR_INDEX_WIDTH-1:0] csr_index;
   logic signed [COEF_WIDTH-1:0]      csr_data;
   int                                fail_count;
   int                                pending_count;
   int                                cycle_count;

   // random idling on both sides while set
   bit                                idle_on = 1'b1;
   // long receiver hold-offs asked for so far
   int                                hold_requests = 0;

   always #(HALF_PERIOD) clock = ~clock;

   biquad_iir_filter dut (.*);

   biquad_response_checker checker_inst (.*);

   // ---------------------------------------------------------------
   // value generators
   // ---------------------------------------------------------------

   // mix of full-range noise, small signals and rail values
   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      case ($urandom_range(3))
         0, 1: return SAMPLE_WIDTH'($urandom);
         2: return SAMPLE_WIDTH'(int'($urandom_range(512)) - 256);
         default: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      endcase
   endfunction

   function automatic logic signed [COEF_WIDTH-1:0] random_coef();
      return COEF_WIDTH'($urandom);
   endfunction

   // coefficients within +-1.0, keeps most filters from pinning at the rails
   function automatic logic signed [COEF_WIDTH-1:0] tame_coef();
      return COEF_WIDTH'(int'($urandom_range(32768)) - 16384);
   endfunction

   // ---------------------------------------------------------------
   // sample channel: drive at the falling edge, look for the transfer at the rising edge
   // ---------------------------------------------------------------
   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] value);
      // occasional gap, long enough to land in any state of the block's pass
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(11)) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_sample_in <= value;
      // hold the payload until the transfer happens
      do @(posedge clock); while (req_stall);
   endtask

   // ---------------------------------------------------------------
   // coefficient writes, only issued while the block is idle
   // ---------------------------------------------------------------
   task automatic write_coef(input logic [CSR_INDEX_WIDTH-1:0] index,
                             input logic signed [COEF_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic program_coefs(input logic signed [COEF_WIDTH-1:0] b0,
                                input logic signed [COEF_WIDTH-1:0] b1,
                                input logic signed [COEF_WIDTH-1:0] b2,
                                input logic signed [COEF_WIDTH-1:0] a1,
                                input logic signed [COEF_WIDTH-1:0] a2);
      write_coef(CSR_B0, b0);
      write_coef(CSR_B1, b1);
      write_coef(CSR_B2, b2);
      write_coef(CSR_A1, a1);
      write_coef(CSR_A2, a2);
   endtask

   // stop offering, let every predicted sample come out, then give the pipeline slack
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int count, input bit with_hold);
      for (int i = 0; i < count; i++) begin
         // receiver freezes while samples keep coming, so the input side backs up
         if (with_hold && i == 20) hold_requests++;
         send_sample(random_sample());
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------
   // result channel: random stall, plus one long counted hold-off on request
   // ---------------------------------------------------------------
   initial begin
      int holds_done;
      holds_done = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests > holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // ---------------------------------------------------------------
   // run limit
   // ---------------------------------------------------------------
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_in = '0;
      csr_write_en  = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // reset coefficients: pass-through, rails and small values
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_WIDTH'(0));
      send_sample(SAMPLE_WIDTH'(1));
      send_sample(SAMPLE_WIDTH'(-1));
      send_sample(SAMPLE_WIDTH'(21845));
      wait_idle();

      // extreme coefficients: output value, state and output all saturate
      program_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
      // writes beyond the five registers must change nothing
      for (int idx = CSR_A2 + 1; idx < 2 ** CSR_INDEX_WIDTH; idx++) begin
         write_coef(CSR_INDEX_WIDTH'(idx), random_coef());
      end
      repeat (3) send_sample(SAMPLE_MAX);
      repeat (3) send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_WIDTH'(0));
      send_sample(SAMPLE_WIDTH'(1));
      wait_idle();

      // every coefficient at its most negative value
      program_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_WIDTH'(0));
      send_sample(SAMPLE_WIDTH'(-1));
      wait_idle();

      // all zero: the old state drains out, then the output is zero whatever goes in
      program_coefs('0, '0, '0, '0, '0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_WIDTH'(1));
      wait_idle();

      // lowpass near fs/10, q about 0.7
      program_coefs(COEF_WIDTH'(1106), COEF_WIDTH'(2210), COEF_WIDTH'(1106),
                    COEF_WIDTH'(-18727), COEF_WIDTH'(6763));
      run_random(ITEMS_PER_PHASE, 1'b0);

      // full-range random coefficients, with the long receiver hold-off
      program_coefs(random_coef(), random_coef(), random_coef(), random_coef(),
                    random_coef());
      run_random(ITEMS_PER_PHASE, 1'b1);

      // back-to-back transfers with no idling on either side
      idle_on = 1'b0;
      program_coefs(tame_coef(), tame_coef(), tame_coef(), tame_coef(), tame_coef());
      run_random(ITEMS_PER_PHASE, 1'b0);
      idle_on = 1'b1;

      // sharp resonator close to instability
      program_coefs(COEF_ONE, COEF_WIDTH'(0), COEF_WIDTH'(-16384),
                    COEF_WIDTH'(-31000), COEF_WIDTH'(15900));
      run_random(ITEMS_PER_PHASE, 1'b0);

      program_coefs(random_coef(), random_coef(), random_coef(), random_coef(),
                    random_coef());
      run_random(ITEMS_PER_PHASE, 1'b0);

      // pure fir: feedback off, random taps
      program_coefs(random_coef(), random_coef(), random_coef(), '0, '0);
      run_random(ITEMS_PER_PHASE, 1'b0);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
